/* rtl/core/srl_pkg.sv */
// Package for the sorted fraction list: widths, request/status codes,
// controller states and the fraction sign-normalization helper.
// No dependencies.
`default_nettype none

package srl_pkg;

  // Field widths
  localparam int DATA_W       = 16;            // numerator / denominator
  localparam int KEY_W        = DATA_W + 1;    // after sign moved to numerator
  localparam int PROD_W       = 2 * KEY_W;     // cross product
  localparam int ENTRY_W      = 2 * DATA_W;    // stored {num, den}
  localparam int REQ_W        = 2;
  localparam int STATUS_W     = 3;
  localparam int CFG_W        = 6;
  localparam int CAPACITY_DEF = 32;
  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(32);

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_SEARCH = 2'd2,
    REQ_DUMP   = 2'd3
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_DUP       = 3'd1,
    ST_FULL      = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_ZERO_DEN  = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BS_RD,
    S_BS_LHS,
    S_BS_RHS,
    S_BS_DEC,
    S_BS_END,
    S_SHIFT,
    S_PUT,
    S_RESP,
    S_DUMP_RD,
    S_DUMP_OUT
  } state_t;

  // Fraction with positive denominator
  typedef struct packed {
    logic signed [KEY_W-1:0] num;
    logic signed [KEY_W-1:0] den;
  } frac_t;

  // Compare unit controls and flags
  typedef struct packed {
    logic load_lhs;
    logic load_rhs;
  } cmp_ctrl_t;

  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_res_t;

  // Move the sign of the denominator into the numerator
  function automatic frac_t norm_frac(logic signed [DATA_W-1:0] n,
                                      logic signed [DATA_W-1:0] d);
    frac_t f;
    if (d < 0) begin
      f.num = -(KEY_W'(n));
      f.den = -(KEY_W'(d));
    end else begin
      f.num = KEY_W'(n);
      f.den = KEY_W'(d);
    end
    return f;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/srl_if.sv */
// Request and response channel interfaces (valid/ready) for the sorted list.
// Depends on srl_pkg.
`default_nettype none

interface srl_req_if;
  import srl_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [REQ_W-1:0]         req_type;
  logic signed [DATA_W-1:0] operand_num;
  logic signed [DATA_W-1:0] operand_den;

  modport source (output valid, req_type, operand_num, operand_den, input ready);
  modport sink   (input valid, req_type, operand_num, operand_den, output ready);
endinterface

interface srl_rsp_if;
  import srl_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic                     found;
  logic signed [DATA_W-1:0] entry_num;
  logic signed [DATA_W-1:0] entry_den;
  logic                     entry_valid;
  logic                     last;

  modport source (output valid, status, found, entry_num, entry_den, entry_valid, last,
                  input ready);
  modport sink   (input valid, status, found, entry_num, entry_den, entry_valid, last,
                  output ready);
endinterface

`default_nettype wire

/* rtl/core/srl_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module srl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/srl_cmp_unit.sv */
// Shared fraction compare unit: one 17x17 multiplier used twice per compare
// (entry_num*key_den, then key_num*entry_den), products registered.
// Depends on srl_pkg.
`default_nettype none

module srl_cmp_unit (
  input  logic                             clk,
  input  srl_pkg::cmp_ctrl_t               ctrl,
  input  logic signed [srl_pkg::DATA_W-1:0] entry_num,
  input  logic signed [srl_pkg::DATA_W-1:0] entry_den,
  input  srl_pkg::frac_t                   key,
  output srl_pkg::cmp_res_t                res
);
  import srl_pkg::*;

  frac_t                   ent;
  logic signed [KEY_W-1:0]  mul_a;
  logic signed [KEY_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] lhs;
  logic signed [PROD_W-1:0] rhs;

  assign ent = norm_frac(entry_num, entry_den);

  // Operand select for the single multiplier
  always_comb begin
    if (ctrl.load_lhs) begin
      mul_a = ent.num;
      mul_b = key.den;
    end else begin
      mul_a = key.num;
      mul_b = ent.den;
    end
  end

  assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Product registers
  always_ff @(posedge clk) begin
    if (ctrl.load_lhs) begin
      lhs <= prod;
    end
    if (ctrl.load_rhs) begin
      rhs <= prod;
    end
  end

  // entry < key, entry == key
  assign res.lt = (lhs < rhs);
  assign res.eq = (lhs == rhs);

endmodule

`default_nettype wire

/* rtl/core/srl_ctrl.sv */
// Sequencer for the sorted list: binary search with the shared compare unit,
// shift of entries through the RAM, dump, and the response output register.
// Depends on srl_pkg, srl_if.
`default_nettype none

module srl_ctrl #(
  parameter int CAPACITY = srl_pkg::CAPACITY_DEF,
  localparam int CNT_W = $clog2(CAPACITY + 1),
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic                              clk,
  input  logic                              rst,
  srl_req_if.sink                           req,
  srl_rsp_if.source                         rsp,
  input  logic [srl_pkg::CFG_W-1:0]         cap_limit,
  output logic                              ram_we,
  output logic [IDX_W-1:0]                  ram_waddr,
  output logic [srl_pkg::ENTRY_W-1:0]       ram_wdata,
  output logic                              ram_re,
  output logic [IDX_W-1:0]                  ram_raddr,
  input  logic [srl_pkg::ENTRY_W-1:0]       ram_rdata,
  output srl_pkg::cmp_ctrl_t                cmp_ctrl,
  output srl_pkg::frac_t                    key,
  input  srl_pkg::cmp_res_t                 cmp_res
);
  import srl_pkg::*;

  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  // Control registers
  state_t           state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic             out_valid, out_valid_next;

  // Working registers
  req_t                     kind, kind_next;
  logic signed [DATA_W-1:0] raw_num, raw_num_next;
  logic signed [DATA_W-1:0] raw_den, raw_den_next;
  frac_t                    key_next;
  logic [CNT_W-1:0]         lo, lo_next;
  logic [CNT_W-1:0]         hi, hi_next;
  logic                     eq, eq_next;
  logic [CNT_W-1:0]         moves, moves_next;
  logic [CNT_W-1:0]         src, src_next;
  logic                     pend, pend_next;
  logic [IDX_W-1:0]         pend_addr, pend_addr_next;
  status_t                  res_status, res_status_next;
  logic                     res_found, res_found_next;

  // Output register
  logic [STATUS_W-1:0]      out_status, out_status_next;
  logic                     out_found, out_found_next;
  logic signed [DATA_W-1:0] out_num, out_num_next;
  logic signed [DATA_W-1:0] out_den, out_den_next;
  logic                     out_evalid, out_evalid_next;
  logic                     out_last, out_last_next;

  logic [CNT_W:0]   mid_sum;
  logic [CNT_W-1:0] mid;
  logic             slot_free;
  logic             full;
  logic             dump_last;
  logic             is_insert;

  assign req.ready       = (state == S_IDLE);
  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.found       = out_found;
  assign rsp.entry_num   = out_num;
  assign rsp.entry_den   = out_den;
  assign rsp.entry_valid = out_evalid;
  assign rsp.last        = out_last;

  assign mid_sum   = {1'b0, lo} + {1'b0, hi};
  assign mid       = mid_sum[CNT_W:1];
  assign slot_free = !out_valid || rsp.ready;
  assign full      = (CMP_W'(count) >= CMP_W'(cap_limit)) || (count == CNT_W'(CAPACITY));
  assign dump_last = ((src + CNT_W'(1)) == count);
  assign is_insert = (kind == REQ_INSERT);

  // Next state and datapath control
  always_comb begin
    state_next      = state;
    count_next      = count;
    kind_next       = kind;
    raw_num_next    = raw_num;
    raw_den_next    = raw_den;
    key_next        = key;
    lo_next         = lo;
    hi_next         = hi;
    eq_next         = eq;
    moves_next      = moves;
    src_next        = src;
    pend_next       = pend;
    pend_addr_next  = pend_addr;
    res_status_next = res_status;
    res_found_next  = res_found;

    out_valid_next  = out_valid && !rsp.ready;
    out_status_next = out_status;
    out_found_next  = out_found;
    out_num_next    = out_num;
    out_den_next    = out_den;
    out_evalid_next = out_evalid;
    out_last_next   = out_last;

    ram_we    = 1'b0;
    ram_waddr = pend_addr;
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = mid[IDX_W-1:0];
    cmp_ctrl  = '0;

    case (state)
      S_IDLE: begin
        if (req.valid) begin
          kind_next      = req_t'(req.req_type);
          raw_num_next   = req.operand_num;
          raw_den_next   = req.operand_den;
          key_next       = norm_frac(req.operand_num, req.operand_den);
          lo_next        = '0;
          hi_next        = count;
          eq_next        = 1'b0;
          src_next       = '0;
          pend_next      = 1'b0;
          res_found_next = 1'b0;
          res_status_next = ST_OK;
          if (req_t'(req.req_type) == REQ_DUMP) begin
            state_next = (count == '0) ? S_RESP : S_DUMP_RD;
          end else if (req.operand_den == '0) begin
            res_status_next = ST_ZERO_DEN;
            state_next      = S_RESP;
          end else if ((req_t'(req.req_type) == REQ_INSERT) && full) begin
            res_status_next = ST_FULL;
            state_next      = S_RESP;
          end else begin
            state_next = S_BS_RD;
          end
        end
      end

      // Binary search for the first entry not below the key
      S_BS_RD: begin
        if (lo < hi) begin
          ram_re     = 1'b1;
          state_next = S_BS_LHS;
        end else begin
          state_next = S_BS_END;
        end
      end

      S_BS_LHS: begin
        cmp_ctrl.load_lhs = 1'b1;
        state_next        = S_BS_RHS;
      end

      S_BS_RHS: begin
        cmp_ctrl.load_rhs = 1'b1;
        state_next        = S_BS_DEC;
      end

      S_BS_DEC: begin
        if (cmp_res.lt) begin
          lo_next = mid + CNT_W'(1);
        end else begin
          hi_next = mid;
          eq_next = cmp_res.eq;
        end
        state_next = S_BS_RD;
      end

      // lo is the order position; eq says the entry there matches
      S_BS_END: begin
        case (kind)
          REQ_SEARCH: begin
            res_status_next = eq ? ST_OK : ST_NOT_FOUND;
            res_found_next  = eq;
            state_next      = S_RESP;
          end
          REQ_INSERT: begin
            if (eq) begin
              res_status_next = ST_DUP;
              state_next      = S_RESP;
            end else begin
              moves_next = count - lo;
              src_next   = count - CNT_W'(1);
              state_next = S_SHIFT;
            end
          end
          default: begin
            if (!eq) begin
              res_status_next = ST_NOT_FOUND;
              state_next      = S_RESP;
            end else begin
              moves_next = count - lo - CNT_W'(1);
              src_next   = lo + CNT_W'(1);
              state_next = S_SHIFT;
            end
          end
        endcase
      end

      // Pipelined move: read one entry per cycle, write it in the following cycle
      S_SHIFT: begin
        if (pend) begin
          ram_we = 1'b1;
        end
        if (moves != '0) begin
          ram_re     = 1'b1;
          ram_raddr  = src[IDX_W-1:0];
          pend_next  = 1'b1;
          moves_next = moves - CNT_W'(1);
          if (is_insert) begin
            pend_addr_next = IDX_W'(src + CNT_W'(1));
            src_next       = src - CNT_W'(1);
          end else begin
            pend_addr_next = IDX_W'(src - CNT_W'(1));
            src_next       = src + CNT_W'(1);
          end
        end else begin
          pend_next = 1'b0;
          if (!pend) begin
            if (is_insert) begin
              state_next = S_PUT;
            end else begin
              count_next = count - CNT_W'(1);
              state_next = S_RESP;
            end
          end
        end
      end

      // Place the new fraction as given
      S_PUT: begin
        ram_we     = 1'b1;
        ram_waddr  = lo[IDX_W-1:0];
        ram_wdata  = {raw_num, raw_den};
        count_next = count + CNT_W'(1);
        state_next = S_RESP;
      end

      // Single-result reply
      S_RESP: begin
        if (slot_free) begin
          out_valid_next  = 1'b1;
          out_status_next = res_status;
          out_found_next  = res_found;
          out_num_next    = '0;
          out_den_next    = '0;
          out_evalid_next = 1'b0;
          out_last_next   = 1'b1;
          state_next      = S_IDLE;
        end
      end

      S_DUMP_RD: begin
        ram_re     = 1'b1;
        ram_raddr  = src[IDX_W-1:0];
        state_next = S_DUMP_OUT;
      end

      S_DUMP_OUT: begin
        if (slot_free) begin
          out_valid_next  = 1'b1;
          out_status_next = ST_OK;
          out_found_next  = 1'b0;
          out_num_next    = ram_rdata[ENTRY_W-1:DATA_W];
          out_den_next    = ram_rdata[DATA_W-1:0];
          out_evalid_next = 1'b1;
          out_last_next   = dump_last;
          if (dump_last) begin
            state_next = S_IDLE;
          end else begin
            src_next   = src + CNT_W'(1);
            state_next = S_DUMP_RD;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    kind       <= kind_next;
    raw_num    <= raw_num_next;
    raw_den    <= raw_den_next;
    key        <= key_next;
    lo         <= lo_next;
    hi         <= hi_next;
    eq         <= eq_next;
    moves      <= moves_next;
    src        <= src_next;
    pend       <= pend_next;
    pend_addr  <= pend_addr_next;
    res_status <= res_status_next;
    res_found  <= res_found_next;
    out_status <= out_status_next;
    out_found  <= out_found_next;
    out_num    <= out_num_next;
    out_den    <= out_den_next;
    out_evalid <= out_evalid_next;
    out_last   <= out_last_next;
  end

endmodule

`default_nettype wire

/* rtl/core/sorted_rational_list.sv */
// Sorted fraction list, top level. Search: each binary-search step is a
// RAM read, two passes through the one multiplier, then decide.
// Insert/remove: search, then the entries behind the slot move one per cycle.
// Dump: RAM read, then output when the slot frees. One request at a time.
// Reset (sync, active high) empties the list and sets the limit to 32;
// stored entries are not cleared, there is no clearing pass.
// Depends on srl_pkg, srl_if, srl_ram, srl_cmp_unit, srl_ctrl.
`default_nettype none

module sorted_rational_list #(
  parameter int CAPACITY = srl_pkg::CAPACITY_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  srl_req_if.sink                   req,
  srl_rsp_if.source                 rsp,
  input  logic                      cfg_we,
  input  logic [srl_pkg::CFG_W-1:0] cfg_wdata
);
  import srl_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic [CFG_W-1:0]   cap_limit;
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic               ram_re;
  logic [IDX_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  cmp_ctrl_t          cmp_ctrl;
  cmp_res_t           cmp_res;
  frac_t              key;

  // Capacity limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      cap_limit <= CFG_RESET;
    end else if (cfg_we) begin
      cap_limit <= cfg_wdata;
    end
  end

  // Entry store {num, den}
  srl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  srl_cmp_unit u_cmp (
    .clk       (clk),
    .ctrl      (cmp_ctrl),
    .entry_num (ram_rdata[ENTRY_W-1:DATA_W]),
    .entry_den (ram_rdata[DATA_W-1:0]),
    .key       (key),
    .res       (cmp_res)
  );

  srl_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .cap_limit (cap_limit),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .cmp_ctrl  (cmp_ctrl),
    .key       (key),
    .cmp_res   (cmp_res)
  );

endmodule

`default_nettype wire
